### design/gptm_pkg.sv
// Shared types and constants for the GPS point trimmed-mean capture block.
`timescale 1ns / 1ps
`default_nettype none

package gptm_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int INDEX_W    = 5;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic                       arm;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] point_x;
        logic signed [SAMPLE_W-1:0] point_y;
        logic [INDEX_W-1:0]         point_index;
        logic                       table_full;
    } t_out_word;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] mean;
    } t_lane_res;

endpackage

`default_nettype wire

### design/gptm_lane.sv
// One axis lane: drops the extremes of a window, sums the rest and divides by the count.
`timescale 1ns / 1ps
`default_nettype none

module gptm_lane #(
    parameter int WINDOW = 5
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_adv,
    input  wire logic                                   i_valid,
    input  wire logic signed [gptm_pkg::SAMPLE_W-1:0]   i_win [WINDOW],
    output gptm_pkg::t_lane_res                         o_res
);
    import gptm_pkg::*;

    localparam int TRIM  = WINDOW - 2;
    localparam int TW    = SAMPLE_W + $clog2(WINDOW) + 1;
    localparam int MW    = TW - 1;
    localparam int QSH   = SAMPLE_W - 1 + 2 * $clog2(TRIM);
    localparam int RB    = QSH + 1 - $clog2(TRIM);
    localparam int LO_W  = RB / 2;
    localparam int HI_W  = RB - LO_W;
    localparam int PLO_W = MW + LO_W;
    localparam int PHI_W = MW + HI_W;
    localparam int PW    = QSH + SAMPLE_W;
    localparam logic [RB-1:0] RECIP =
        RB'(((64'd1 << QSH) + 64'(TRIM) - 64'd1) / 64'(TRIM));
    localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
    localparam logic [HI_W-1:0] RECIP_HI = RECIP[RB-1:LO_W];

    logic signed [SAMPLE_W-1:0] r_win [WINDOW];
    logic                       r_v0;

    logic signed [TW-1:0]       r_total;
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;
    logic                       r_v1;

    logic signed [TW-1:0]       n_total;
    logic signed [SAMPLE_W-1:0] n_min;
    logic signed [SAMPLE_W-1:0] n_max;

    logic signed [TW-1:0]       mid;
    logic signed [TW-1:0]       mid_abs;

    logic [MW-1:0]              r_abs;
    logic [PLO_W-1:0]           r_plo;
    logic [PHI_W-1:0]           r_phi;
    logic [PLO_W-1:0]           n_plo;
    logic [PHI_W-1:0]           n_phi;
    logic [PW-1:0]              n_prod;
    logic [SAMPLE_W-1:0]        r_quo;
    logic [2:0]                 r_neg;
    logic [2:0]                 r_dv;

    always_comb begin
        n_total = '0;
        n_min   = r_win[0];
        n_max   = r_win[0];
        for (int i = 0; i < WINDOW; i++) begin
            n_total = n_total + TW'(r_win[i]);
        end
        for (int i = 1; i < WINDOW; i++) begin
            if (r_win[i] < n_min) begin
                n_min = r_win[i];
            end
            if (r_win[i] > n_max) begin
                n_max = r_win[i];
            end
        end
    end

    assign mid     = r_total - TW'(r_min) - TW'(r_max);
    assign mid_abs = mid[TW-1] ? -mid : mid;

    // The quotient is the magnitude times a scaled reciprocal of the count, split into
    // two partial products so that no single multiplier grows too wide.
    assign n_plo  = PLO_W'(r_abs) * PLO_W'(RECIP_LO);
    assign n_phi  = PHI_W'(r_abs) * PHI_W'(RECIP_HI);
    assign n_prod = PW'(r_plo) + (PW'(r_phi) << LO_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_dv <= '0;
        end else if (i_adv) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_dv <= {r_dv[1:0], r_v1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_win   <= i_win;
            r_total <= n_total;
            r_min   <= n_min;
            r_max   <= n_max;
            r_abs   <= mid_abs[MW-1:0];
            r_neg   <= {r_neg[1:0], mid[TW-1]};
            r_plo   <= n_plo;
            r_phi   <= n_phi;
            r_quo   <= n_prod[QSH +: SAMPLE_W];
        end
    end

    assign o_res.valid = r_dv[2];
    assign o_res.mean  = signed'(r_neg[2] ? -r_quo : r_quo);

endmodule

`default_nettype wire

### design/gptm_merge.sv
// Output stage: joins the two lane means with the table slot into one result word.
`timescale 1ns / 1ps
`default_nettype none

module gptm_merge #(
    parameter int MAX_POINTS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire gptm_pkg::t_lane_res   i_res_x,
    input  wire gptm_pkg::t_lane_res   i_res_y,
    output logic                       o_adv,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output gptm_pkg::t_out_word        o_out_word
);
    import gptm_pkg::*;

    localparam int PT_W = $clog2(MAX_POINTS + 1);

    logic                      r_out_valid;
    t_out_word                 r_out_word;
    logic [PT_W-1:0]           r_points;

    logic                      full;
    logic [PT_W-1:0]           idx;
    logic [PT_W+INDEX_W-1:0]   idx_ext;
    t_out_word                 n_out_word;

    assign o_adv   = !r_out_valid || i_out_ready;
    assign full    = r_points >= PT_W'(MAX_POINTS);
    assign idx     = full ? PT_W'(MAX_POINTS - 1) : r_points;
    assign idx_ext = {{INDEX_W{1'b0}}, idx};

    always_comb begin
        n_out_word.point_x     = i_res_x.mean;
        n_out_word.point_y     = i_res_y.mean;
        n_out_word.point_index = idx_ext[INDEX_W-1:0];
        n_out_word.table_full  = full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_points    <= '0;
        end else if (o_adv) begin
            r_out_valid <= i_res_x.valid;
            if (i_res_x.valid && !full) begin
                r_points <= r_points + PT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_res_x.valid) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

### design/gps_point_trimmed_mean_capture.sv
// Top level of the GPS point trimmed-mean capture block.
// An armed capture shifts WINDOW samples per axis into a window and, on the next sample,
// emits the mean of the window with its smallest and largest values dropped, rounded
// toward zero, together with its table slot; the block then disarms. The block takes one
// word per cycle, save for the stall described below. The edge that accepts the word completing
// the window loads the lane window register; four more lane stages (sum and extremes,
// magnitude, partial products of a reciprocal multiply, quotient) and the output register
// follow before the result appears. While a finished result waits at the output, words keep
// being taken, except the one that would complete the next capture.
`timescale 1ns / 1ps
`default_nettype none

module gps_point_trimmed_mean_capture #(
    parameter int WINDOW     = 5,
    parameter int MAX_POINTS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire gptm_pkg::t_in_word    i_in_word,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output gptm_pkg::t_out_word        o_out_word
);
    import gptm_pkg::*;

    localparam int CNT_W = $clog2(WINDOW + 1);

    logic                       r_armed;
    logic [CNT_W-1:0]           r_count;
    logic signed [SAMPLE_W-1:0] r_win_x [WINDOW];
    logic signed [SAMPLE_W-1:0] r_win_y [WINDOW];
    logic signed [SAMPLE_W-1:0] n_win_x [WINDOW];
    logic signed [SAMPLE_W-1:0] n_win_y [WINDOW];

    logic       adv;
    logic       in_fire;
    logic       armed_now;
    logic       shift;
    logic       win_done;
    logic       capture;
    t_lane_res  res_x;
    t_lane_res  res_y;

    assign win_done   = r_count == CNT_W'(WINDOW);
    assign o_in_ready = adv || !win_done;
    assign in_fire    = i_in_valid && o_in_ready;
    assign armed_now  = r_armed || i_in_word.arm;
    assign shift      = in_fire && armed_now;
    assign capture    = shift && win_done;

    always_comb begin
        n_win_x[0] = i_in_word.sample_x;
        n_win_y[0] = i_in_word.sample_y;
        for (int i = 1; i < WINDOW; i++) begin
            n_win_x[i] = r_win_x[i-1];
            n_win_y[i] = r_win_y[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_count <= '0;
        end else if (shift) begin
            if (win_done) begin
                r_armed <= 1'b0;
                r_count <= '0;
            end else begin
                r_armed <= 1'b1;
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_win_x <= n_win_x;
            r_win_y <= n_win_y;
        end
    end

    gptm_lane #(
        .WINDOW (WINDOW)
    ) u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (capture),
        .i_win   (n_win_x),
        .o_res   (res_x)
    );

    gptm_lane #(
        .WINDOW (WINDOW)
    ) u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (capture),
        .i_win   (n_win_y),
        .o_res   (res_y)
    );

    gptm_merge #(
        .MAX_POINTS (MAX_POINTS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_x     (res_x),
        .i_res_y     (res_y),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WINDOW))
        else $error("Sample count ran past the window depth.");

    a_count_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 |-> r_armed)
        else $error("Samples counted while the capture is not armed.");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_x.valid == res_y.valid)
        else $error("The two axis lanes are out of step.");

    a_capture_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        capture |=> !r_armed && r_count == '0)
        else $error("A completed capture did not disarm the block.");

endmodule

`default_nettype wire

### tb/sv/gps_point_trimmed_mean_capture_tb.sv
// Testbench for the GPS point trimmed-mean capture block, checked against a scoreboard.
`timescale 1ns / 1ps

module gps_point_trimmed_mean_capture_tb;

    import gptm_pkg::*;

    localparam int WIN_DEPTH   = 5;
    localparam int TABLE_SLOTS = 32;
    localparam int ITEMS       = 800;
    localparam int CALM_TAIL   = 120;
    localparam int LONG_HOLD   = 150;
    localparam int SETTLE      = 20;
    localparam int TIMEOUT_NS  = 5_000_000;

    localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fff_ffff;

    class waypoint_checker;
        logic                       armed;
        logic [2:0]                 fill;
        logic [5:0]                 taken;
        logic signed [SAMPLE_W-1:0] win_x [WIN_DEPTH];
        logic signed [SAMPLE_W-1:0] win_y [WIN_DEPTH];
        t_out_word                  pending_points [$];
        int                         samples_used;
        int                         mismatches;

        function new();
            armed = 1'b0;
            fill = '0;
            taken = '0;
            foreach (win_x[i]) begin
                win_x[i] = '0;
                win_y[i] = '0;
            end
            samples_used = 0;
            mismatches = 0;
        endfunction

        function logic signed [SAMPLE_W-1:0] mid_mean(
            input logic signed [SAMPLE_W-1:0] v [WIN_DEPTH]
        );
            logic signed [SAMPLE_W-1:0] s [WIN_DEPTH];
            logic signed [SAMPLE_W-1:0] t;
            longint acc;
            s = v;
            for (int i = 1; i < WIN_DEPTH; i++) begin
                for (int j = 1; j <= WIN_DEPTH - i; j++) begin
                    if (s[j-1] > s[j]) begin
                        t = s[j-1];
                        s[j-1] = s[j];
                        s[j] = t;
                    end
                end
            end
            acc = 0;
            for (int i = 1; i < WIN_DEPTH - 1; i++) begin
                acc += s[i];
            end
            acc = acc / (WIN_DEPTH - 2);
            return acc[SAMPLE_W-1:0];
        endfunction

        function void take_sample(input t_in_word w);
            t_out_word pt;
            if (w.arm) begin
                armed = 1'b1;
            end
            if (!armed) begin
                return;
            end
            samples_used++;
            for (int i = WIN_DEPTH - 1; i > 0; i--) begin
                win_x[i] = win_x[i-1];
                win_y[i] = win_y[i-1];
            end
            win_x[0] = w.sample_x;
            win_y[0] = w.sample_y;
            if (fill < WIN_DEPTH) begin
                fill++;
                return;
            end
            pt.point_x = mid_mean(win_x);
            pt.point_y = mid_mean(win_y);
            pt.table_full = (taken >= TABLE_SLOTS);
            pt.point_index = pt.table_full ? INDEX_W'(TABLE_SLOTS - 1) : taken[INDEX_W-1:0];
            if (!pt.table_full) begin
                taken++;
            end
            fill = '0;
            armed = 1'b0;
            pending_points.push_back(pt);
        endfunction

        task report_mismatch(input string what, input t_out_word got, input t_out_word want);
            mismatches++;
            $display("%0t mismatch, %s: got x=%0d y=%0d idx=%0d full=%0b, %s",
                     $realtime, what, got.point_x, got.point_y, got.point_index,
                     got.table_full,
                     $sformatf("want x=%0d y=%0d idx=%0d full=%0b", want.point_x,
                               want.point_y, want.point_index, want.table_full));
        endtask

        task check_point(input t_out_word got);
            t_out_word want;
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected point", got, '0);
                return;
            end
            want = pending_points.pop_front();
            if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
                got.point_index !== want.point_index || got.table_full !== want.table_full) begin
                report_mismatch("wrong field", got, want);
            end
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_word;

    waypoint_checker sb = new();

    logic calm = 1'b0;
    logic hold_req = 1'b0;
    logic tx_gappy = 1'b0;
    int   tx_left = 0;

    always #5 i_clk = ~i_clk;

    gps_point_trimmed_mean_capture dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always @(posedge i_clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                sb.take_sample(in_word);
            end
            if (out_valid && out_ready) begin
                sb.check_point(out_word);
            end
        end
    end

    initial begin
        int  quiet_left;
        logic rx_stalls;
        quiet_left = 0;
        rx_stalls = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (quiet_left == 0) begin
                rx_stalls = ($urandom_range(0, 2) != 0);
                quiet_left = $urandom_range(20, 120);
            end
            quiet_left--;
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (rx_stalls && !calm && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] coord(input logic signed [SAMPLE_W-1:0] base);
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return S_MIN;
            3:       return S_MAX;
            4, 5:    return $urandom_range(0, 40) - 20;
            default: return base + ($urandom_range(0, 4000) - 2000);
        endcase
    endfunction

    task automatic offer(input logic signed [SAMPLE_W-1:0] x, input logic signed [SAMPLE_W-1:0] y,
                         input logic arm);
        in_valid <= 1'b1;
        in_word <= '{sample_x: x, sample_y: y, arm: arm};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        if (tx_left == 0) begin
            tx_gappy = ($urandom_range(0, 2) != 0);
            tx_left = $urandom_range(15, 60);
        end
        tx_left--;
        if (tx_gappy && !calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic run_capture(input int words);
        logic signed [SAMPLE_W-1:0] base_x;
        logic signed [SAMPLE_W-1:0] base_y;
        base_x = $urandom;
        base_y = $urandom;
        for (int i = 0; i < words; i++) begin
            offer(coord(base_x), coord(base_y), (i == 0) ? 1'b1 : ($urandom_range(0, 4) == 0));
        end
    endtask

    initial begin
        int   kind;
        logic held;
        logic drained;
        held = 1'b0;
        drained = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_word <= '0;
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // A word that arrives while the block is not armed is dropped.
        offer(32'sd123, -32'sd456, 1'b0);

        // Full-scale values, with a second arm during the capture.
        offer(S_MIN, S_MIN, 1'b1);
        offer(S_MAX, S_MIN, 1'b0);
        offer(S_MAX, S_MIN, 1'b1);
        offer(S_MAX, S_MIN, 1'b0);
        offer(S_MIN, S_MIN, 1'b0);
        offer(S_MIN, S_MIN, 1'b0);

        // A negative mean that must round toward zero, not down.
        offer(32'sd99, S_MAX, 1'b1);
        offer(-32'sd2, S_MAX, 1'b0);
        offer(-32'sd2, S_MAX, 1'b0);
        offer(32'sd0, S_MAX, 1'b0);
        offer(-32'sd10, S_MAX, 1'b0);
        offer(32'sd10, S_MAX, 1'b0);

        offer(S_MAX, S_MIN, 1'b0);
        offer(-32'sd1, 32'sd1, 1'b0);

        offer(32'sd0, 32'sd1, 1'b1);
        offer(32'sd0, 32'sd1, 1'b0);
        offer(32'sd0, 32'sd2, 1'b0);
        offer(32'sd0, -32'sd7, 1'b0);
        offer(-32'sd1, 32'sd2, 1'b0);
        offer(32'sd1, 32'sd40, 1'b0);

        while (sb.samples_used < ITEMS) begin
            calm = (sb.samples_used > ITEMS - CALM_TAIL);
            if (!held && sb.samples_used > 250) begin
                held = 1'b1;
                hold_req = 1'b1;
            end
            if (!drained && sb.samples_used > 450) begin
                drained = 1'b1;
                in_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending_points.size() != 0) @(posedge i_clk);
                repeat (SETTLE) @(posedge i_clk);
            end
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                run_capture(WIN_DEPTH + 1);
            end else if (kind < 9) begin
                repeat ($urandom_range(1, 4)) offer(coord($urandom), coord($urandom), 1'b0);
            end else begin
                run_capture($urandom_range(1, 4));
            end
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.pending_points.size() != 0) begin
            sb.report_mismatch("point never arrived", '0, sb.pending_points[0]);
        end
        if (sb.mismatches == 0) begin
            $display("gps_point_trimmed_mean_capture_tb: PASS");
        end else begin
            $display("gps_point_trimmed_mean_capture_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("gps_point_trimmed_mean_capture_tb: FAIL");
        $finish;
    end

endmodule

### files.f
design/gptm_pkg.sv
design/gptm_lane.sv
design/gptm_merge.sv
design/gps_point_trimmed_mean_capture.sv
tb/sv/gps_point_trimmed_mean_capture_tb.sv
